/* sv/cbd_pkg.sv */
// Shared types and constants for the chunked body deframer.
// No dependencies; imported by every module of the block.
package cbd_pkg;

    // parser phase codes
    localparam logic [2:0] PH_SIZE  = 3'd0;
    localparam logic [2:0] PH_SKIP1 = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_SKIP2 = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_ERR   = 2'd3;

    // characters of interest
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [1:0] SKIP_TRAILER = 2'd2;
    localparam logic [23:0] MAX_BODY_RST = 24'd4096;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_byte;
        logic        is_last;
        logic [23:0] body_length;
    } res_t;

    // {is_hex, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
            r = {1'b1, 4'(c - 8'h30)};
        else if (c inside {[8'h61:8'h66]})
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        else if (c inside {[8'h41:8'h46]})
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        return r;
    endfunction

endpackage

/* sv/chunked_body_deframer_top.sv */
// Chunked body deframer, one byte per transfer in, at most one result out.
// Usage:
//   Input channel (in_valid / in_stall, kind, data_byte): kind 1 starts a new
//   body and clears the parser; kind 0 carries one raw byte of the stream.
//   Output channel (out_valid / out_stall): status, data_byte_res, is_last,
//   body_length. Body bytes come out with status data; the body ends with
//   one result marked is_last (complete, truncated or error), after which
//   stream bytes are dropped until the next kind 1 transfer.
//   User writes max_body (max_body_we) with no transfer in flight; unchecked.
// Timing:
//   An accepted byte passes two register stages, the input register and
//   then the result register. One byte per cycle is sustained while no
//   result is stalled; a size digit needs one shift-add, a data byte one
//   decrement. When out_stall holds a result, one more byte may sit in the
//   input register; in_stall rises only when both stages are full.
// Reset: rst_n clears both stages and the parser; max_body returns to 4096.
// Depends on cbd_pkg, cbd_in_stage, cbd_parser, cbd_out_stage.
module chunked_body_deframer_top
    import cbd_pkg::*;
#(
    parameter int LENGTH_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    input  logic        max_body_we,
    input  logic [23:0] max_body,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  data_byte_res,
    output logic        is_last,
    output logic [23:0] body_length
);

    logic  item_valid;
    item_t item;
    logic  ready;
    logic  step;
    logic  res_valid;
    res_t  res;

    assign step = item_valid && ready;

    cbd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .data_byte  (data_byte),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    cbd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (max_body_we),
        .cfg_data  (max_body),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    cbd_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .ready         (ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .data_byte_res (data_byte_res),
        .is_last       (is_last),
        .body_length   (body_length)
    );

endmodule

/* sv/cbd_in_stage.sv */
// Input register of the deframer: captures one transfer per cycle while in_stall is low.
// Depends on cbd_pkg.
module cbd_in_stage
    import cbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] data_byte,
    input  logic       take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg, valid_next;
    item_t item_reg;

    assign in_stall   = valid_reg && !take;
    assign valid_next = (valid_reg && !take) || in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= '{kind: kind, data_byte: data_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* sv/cbd_parser.sv */
// Chunk framing parser: size line decode, skip, data pass and limit check.
// Holds the max_body register. Depends on cbd_pkg.
module cbd_parser
    import cbd_pkg::*;
#(
    parameter int LENGTH_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_data,
    input  logic        step,
    input  item_t       item,
    output logic        res_valid,
    output res_t        res
);

    localparam int CNT_W = (LENGTH_BITS < 24) ? LENGTH_BITS : 24;
    localparam logic [24:0] CAP_W = (25'd1 << CNT_W) - 25'd1;
    localparam logic [23:0] CAP = CAP_W[23:0];

    logic [23:0]      max_body_reg;
    logic [2:0]       phase_reg, phase_next;
    logic [30:0]      size_reg, size_next;
    logic             ovf_reg, ovf_next;
    logic [30:0]      remain_reg, remain_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       skip_reg, skip_next;
    logic             begun_reg, begun_next;
    logic             ended_reg, ended_next;
    logic             neg_reg, neg_next;
    logic             sign_reg, sign_next;

    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] count_inc;
    logic [4:0]       hx;
    logic [7:0]       c;
    logic             emit;

    assign limit     = (max_body_reg > CAP) ? CAP[CNT_W-1:0] : max_body_reg[CNT_W-1:0];
    assign count_inc = count_reg + CNT_W'(1);
    assign c         = item.data_byte;
    assign hx        = hex_digit(c);

    always_comb
    begin
        phase_next  = phase_reg;
        size_next   = size_reg;
        ovf_next    = ovf_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        skip_next   = skip_reg;
        begun_next  = begun_reg;
        ended_next  = ended_reg;
        neg_next    = neg_reg;
        sign_next   = sign_reg;
        emit        = 1'b0;
        res.status      = ST_DATA;
        res.data_byte   = 8'd0;
        res.is_last     = 1'b0;

        if (item.kind)
        begin
            phase_next  = PH_SIZE;
            size_next   = '0;
            ovf_next    = 1'b0;
            remain_next = '0;
            count_next  = '0;
            skip_next   = '0;
            begun_next  = 1'b0;
            ended_next  = 1'b0;
            neg_next    = 1'b0;
            sign_next   = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_SIZE:
                begin
                    if (c == CH_CR || c == CH_LF)
                    begin
                        if (ovf_reg)
                        begin
                            emit = 1'b1;
                            res.status = ST_ERR;
                            res.is_last = 1'b1;
                        end
                        else if (size_reg == '0)
                        begin
                            emit = 1'b1;
                            res.status = ST_DONE;
                            res.is_last = 1'b1;
                        end
                        else if (neg_reg)
                        begin
                            emit = 1'b1;
                            res.status = ST_ERR;
                            res.is_last = 1'b1;
                        end
                        else
                        begin
                            remain_next = size_reg;
                            phase_next  = PH_SKIP1;
                        end
                    end
                    else if (!ended_reg)
                    begin
                        if (hx[4])
                        begin
                            begun_next = 1'b1;
                            // any further nibble on a value that needs more than 27 bits overflows
                            if (ovf_reg || size_reg[30:27] != 4'd0)
                            begin
                                ovf_next  = 1'b1;
                                size_next = '0;
                            end
                            else
                            begin
                                size_next = {size_reg[26:0], hx[3:0]};
                            end
                        end
                        else if (!begun_reg && !sign_reg &&
                                 (c inside {CH_SP, CH_TAB, CH_VT, CH_FF}))
                        begin
                            ended_next = 1'b0;
                        end
                        else if (!begun_reg && !sign_reg &&
                                 (c inside {CH_PLUS, CH_MINUS}))
                        begin
                            sign_next = 1'b1;
                            neg_next  = (c == CH_MINUS);
                        end
                        else
                        begin
                            ended_next = 1'b1;
                        end
                    end
                end
                PH_SKIP1:
                begin
                    phase_next = PH_DATA;
                    if (count_reg >= limit)
                    begin
                        emit = 1'b1;
                        res.status = ST_TRUNC;
                        res.is_last = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    emit = 1'b1;
                    if (count_reg >= limit)
                    begin
                        res.status = ST_TRUNC;
                        res.is_last = 1'b1;
                    end
                    else
                    begin
                        count_next    = count_inc;
                        remain_next   = remain_reg - 31'd1;
                        res.data_byte = c;
                        if (count_inc >= limit)
                        begin
                            res.status = ST_TRUNC;
                            res.is_last = 1'b1;
                        end
                        else if (remain_reg == 31'd1)
                        begin
                            phase_next = PH_SKIP2;
                            skip_next  = SKIP_TRAILER;
                        end
                    end
                end
                PH_SKIP2:
                begin
                    if (skip_reg <= 2'd1)
                    begin
                        skip_next  = 2'd0;
                        phase_next = PH_SIZE;
                        size_next  = '0;
                        ovf_next   = 1'b0;
                        begun_next = 1'b0;
                        ended_next = 1'b0;
                        neg_next   = 1'b0;
                        sign_next  = 1'b0;
                    end
                    else
                    begin
                        skip_next = skip_reg - 2'd1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (emit && res.is_last)
            begin
                phase_next = PH_DONE;
            end
        end
        res.body_length = 24'(count_next);
    end

    assign res_valid = step && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg <= MAX_BODY_RST;
            phase_reg    <= PH_SIZE;
            size_reg     <= '0;
            ovf_reg      <= 1'b0;
            remain_reg   <= '0;
            count_reg    <= '0;
            skip_reg     <= '0;
            begun_reg    <= 1'b0;
            ended_reg    <= 1'b0;
            neg_reg      <= 1'b0;
            sign_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_body_reg <= cfg_data;
            end
            if (step)
            begin
                phase_reg  <= phase_next;
                size_reg   <= size_next;
                ovf_reg    <= ovf_next;
                remain_reg <= remain_next;
                count_reg  <= count_next;
                skip_reg   <= skip_next;
                begun_reg  <= begun_next;
                ended_reg  <= ended_next;
                neg_reg    <= neg_next;
                sign_reg   <= sign_next;
            end
        end
    end

endmodule

/* sv/cbd_out_stage.sv */
// Result register of the deframer; holds a result while the receiver stalls.
// Depends on cbd_pkg.
module cbd_out_stage
    import cbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  res_t        res,
    output logic        ready,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  data_byte_res,
    output logic        is_last,
    output logic [23:0] body_length
);

    logic valid_reg, valid_next;
    res_t res_reg;

    assign ready      = !valid_reg || !out_stall;
    assign valid_next = ready ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign status        = res_reg.status;
    assign data_byte_res = res_reg.data_byte;
    assign is_last       = res_reg.is_last;
    assign body_length   = res_reg.body_length;

endmodule

/* sv/cbd_checker.sv */
// Port-level checks for the chunked body deframer, bound to the top level.
// Depends on cbd_pkg and chunked_body_deframer_top.
module cbd_checker
    import cbd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [7:0]  data_byte_res,
    input logic        is_last,
    input logic [23:0] body_length
);

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) &&
        $stable(data_byte_res) && $stable(is_last) && $stable(body_length))
        else $error("result changed while stalled");

    // only the closing result carries is_last
    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == ST_DATA) == !is_last))
        else $error("is_last does not match status");

    // complete and error results carry no byte
    a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_DONE || status == ST_ERR) |-> data_byte_res == 8'd0)
        else $error("byte on complete or error result");

    // a passed byte is always counted
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DATA |-> body_length != 24'd0)
        else $error("data result with zero length");

endmodule

bind chunked_body_deframer_top cbd_checker u_cbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .data_byte_res (data_byte_res),
    .is_last       (is_last),
    .body_length   (body_length)
);
